>>> rtl/core/kabf_pkg.sv
// kabf_pkg: shared types, constants and saturation helpers for the angle/bias Kalman filter.
// No dependencies; imported by kabf_mul, kabf_div and angle_bias_kalman_filter_top.
`default_nettype none

package kabf_pkg;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    // micro-op sequence, executed in declaration order
    typedef enum logic [3:0]
    {
        OP_ANG,
        OP_P00,
        OP_P11DT,
        OP_P11Q,
        OP_K0,
        OP_K1,
        OP_U00,
        OP_U01,
        OP_U10,
        OP_U11,
        OP_CA,
        OP_CB
    } op_t;

    typedef struct packed
    {
        logic start;
        logic sh40;     // 1: shift by 40, 0: shift by 28
    } mul_ctl_t;

    localparam logic [1:0] REG_STEP_TIME     = 2'd0;
    localparam logic [1:0] REG_ANGLE_NOISE   = 2'd1;
    localparam logic [1:0] REG_BIAS_NOISE    = 2'd2;
    localparam logic [1:0] REG_MEASURE_NOISE = 2'd3;

    localparam logic [31:0] STEP_TIME_RST     = 32'd5368709;
    localparam logic [31:0] ANGLE_NOISE_RST   = 32'd268435;
    localparam logic [31:0] BIAS_NOISE_RST    = 32'd805306;
    localparam logic [31:0] MEASURE_NOISE_RST = 32'd134217728;

    localparam logic signed [47:0] COV_ONE = 48'sh010000000000;
    localparam logic [63:0] CLAMP_LIM = 64'h4000000000000000;

    function automatic logic [63:0] magn(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sh000000007FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < 64'shFFFFFFFF80000000)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        if (v > 64'sh00007FFFFFFFFFFF)
            return 48'sh7FFFFFFFFFFF;
        else if (v < 64'shFFFF800000000000)
            return 48'sh800000000000;
        else
            return v[47:0];
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/angle_bias_kalman_filter_top.sv
// angle_bias_kalman_filter_top: per-axis two-state Kalman filter, sequencer, state and APB regs.
// Depends on kabf_pkg, kabf_mul, kabf_div.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser: axis; s_tdata: accel_angle, gyro_rate
// m_       out  m_tvalid/m_tready  m_tuser: axis_out; m_tdata: filtered_angle, corrected_rate
// apb      in   psel/penable       paddr, pwdata, prdata (4 regs, 32 bit)
//
// Each item runs ten products on the shared 64x16 multiplier and two gain divisions on the
// 1-bit-per-cycle divider, then an output state and an idle state before the next accept.
// A zero gain divisor skips both divisions. Reset sets the registers to defaults, angle and
// bias to 0 and the covariance to identity. The input side is ready only when idle; a result
// waits on m_ until taken.
`default_nettype none

module angle_bias_kalman_filter_top
    import kabf_pkg::*;
#(
    parameter int NUM_AXES = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
    input  wire logic [0:0]  s_tuser,   // [0] axis
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // [31:0] filtered_angle, [63:32] corrected_rate
    output logic [0:0]       m_tuser,   // [0] axis_out
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

    seq_state_t state_reg, state_next;
    op_t        op_reg;

    logic [31:0] step_time_reg, angle_noise_reg, bias_noise_reg, measure_noise_reg;

    logic signed [31:0] est_arr_reg  [NUM_AXES];
    logic signed [31:0] bias_arr_reg [NUM_AXES];
    logic signed [47:0] p00_arr_reg  [NUM_AXES];
    logic signed [47:0] p01_arr_reg  [NUM_AXES];
    logic signed [47:0] p10_arr_reg  [NUM_AXES];
    logic signed [47:0] p11_arr_reg  [NUM_AXES];

    logic               axis_reg;
    logic [AW-1:0]      ai_reg;
    logic signed [31:0] accel_reg, gyro_reg, ang_reg, bias_old_reg, rate_out_reg;
    logic signed [32:0] err_reg;
    logic signed [47:0] p00_reg, p01_reg, p10_reg, p11_reg;
    logic signed [47:0] k0_reg, k1_reg, t0_reg, t1_reg;

    logic [AW-1:0]      ai_in;
    logic               accept;
    logic               is_div;
    logic               e_zero;
    logic               unit_done;
    logic               step_done;
    logic               cfg_wr;
    logic signed [63:0] qa, qg, rr, dt, e_w;
    logic signed [63:0] mul_a, mul_b, div_num, res_w;
    logic signed [63:0] mul_res, div_res;
    logic               mul_done, div_done, div_start;
    logic               sh40;
    mul_ctl_t           mul_ctl;
    logic signed [31:0] ang_pred, bias_new;

    assign ai_in  = (NUM_AXES > 1) ? AW'(s_tuser[0]) : '0;
    assign accept = s_tvalid && s_tready;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign dt  = {32'b0, step_time_reg};
    assign qa  = {20'b0, angle_noise_reg, 12'b0};
    assign qg  = {20'b0, bias_noise_reg, 12'b0};
    assign rr  = {20'b0, measure_noise_reg, 12'b0};
    assign e_w = rr + 64'(p00_reg);

    assign is_div    = (op_reg == OP_K0) || (op_reg == OP_K1);
    assign e_zero    = (e_w == 64'sd0);
    assign unit_done = is_div ? div_done : mul_done;
    assign step_done = ((state_reg == ST_WAIT) && unit_done)
                    || ((state_reg == ST_ISSUE) && is_div && e_zero);
    assign res_w     = is_div ? (e_zero ? 64'sd0 : div_res) : mul_res;

    assign ang_pred = sat32(64'(ang_reg) + res_w);
    assign bias_new = sat32(64'(bias_old_reg) + res_w);

    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        sh40    = 1'b1;
        div_num = (op_reg == OP_K1) ? 64'(p10_reg) : 64'(p00_reg);
        case (op_reg)
            OP_ANG:
            begin
                mul_a = 64'(gyro_reg) - 64'(bias_old_reg);
                mul_b = dt;
                sh40  = 1'b0;
            end
            OP_P00:
            begin
                mul_a = qa - 64'(p01_reg) - 64'(p10_reg);
                mul_b = dt;
                sh40  = 1'b0;
            end
            OP_P11DT:
            begin
                mul_a = 64'(p11_reg);
                mul_b = dt;
                sh40  = 1'b0;
            end
            OP_P11Q:
            begin
                mul_a = qg;
                mul_b = dt;
                sh40  = 1'b0;
            end
            OP_U00:
            begin
                mul_a = 64'(k0_reg);
                mul_b = 64'(t0_reg);
            end
            OP_U01:
            begin
                mul_a = 64'(k0_reg);
                mul_b = 64'(t1_reg);
            end
            OP_U10:
            begin
                mul_a = 64'(k1_reg);
                mul_b = 64'(t0_reg);
            end
            OP_U11:
            begin
                mul_a = 64'(k1_reg);
                mul_b = 64'(t1_reg);
            end
            OP_CA:
            begin
                mul_a = 64'(k0_reg);
                mul_b = 64'(err_reg);
            end
            OP_CB:
            begin
                mul_a = 64'(k1_reg);
                mul_b = 64'(err_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_ISSUE;
            ST_ISSUE:
                if (!(is_div && e_zero))
                    state_next = ST_WAIT;
            ST_WAIT:
                if (unit_done)
                    state_next = (op_reg == OP_CB) ? ST_OUT : ST_ISSUE;
            ST_OUT:
                if (m_tready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_tready      = 1'b0;
        m_tvalid      = 1'b0;
        mul_ctl.start = 1'b0;
        mul_ctl.sh40  = sh40;
        div_start     = 1'b0;
        case (state_reg)
            ST_IDLE:
                s_tready = 1'b1;
            ST_ISSUE:
            begin
                mul_ctl.start = !is_div;
                div_start     = is_div && !e_zero;
            end
            ST_OUT:
                m_tvalid = 1'b1;
            default:
                s_tready = 1'b0;
        endcase
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_STEP_TIME:     prdata = step_time_reg;
            REG_ANGLE_NOISE:   prdata = angle_noise_reg;
            REG_BIAS_NOISE:    prdata = bias_noise_reg;
            REG_MEASURE_NOISE: prdata = measure_noise_reg;
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            op_reg            <= OP_ANG;
            step_time_reg     <= STEP_TIME_RST;
            angle_noise_reg   <= ANGLE_NOISE_RST;
            bias_noise_reg    <= BIAS_NOISE_RST;
            measure_noise_reg <= MEASURE_NOISE_RST;
            for (int k = 0; k < NUM_AXES; k++)
            begin
                est_arr_reg[k]  <= '0;
                bias_arr_reg[k] <= '0;
                p00_arr_reg[k]  <= COV_ONE;
                p01_arr_reg[k]  <= '0;
                p10_arr_reg[k]  <= '0;
                p11_arr_reg[k]  <= COV_ONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                op_reg <= OP_ANG;
            else if (step_done && (op_reg != OP_CB))
                op_reg <= op_t'(op_reg + 4'd1);

            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_STEP_TIME:     step_time_reg     <= pwdata;
                    REG_ANGLE_NOISE:   angle_noise_reg   <= pwdata;
                    REG_BIAS_NOISE:    bias_noise_reg    <= pwdata;
                    REG_MEASURE_NOISE: measure_noise_reg <= pwdata;
                    default:           step_time_reg     <= step_time_reg;
                endcase
            end

            if (step_done && (op_reg == OP_CB))
            begin
                est_arr_reg[ai_reg]  <= ang_reg;
                bias_arr_reg[ai_reg] <= bias_new;
                p00_arr_reg[ai_reg]  <= p00_reg;
                p01_arr_reg[ai_reg]  <= p01_reg;
                p10_arr_reg[ai_reg]  <= p10_reg;
                p11_arr_reg[ai_reg]  <= p11_reg;
            end
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            axis_reg     <= s_tuser[0];
            ai_reg       <= ai_in;
            accel_reg    <= s_tdata[31:0];
            gyro_reg     <= s_tdata[63:32];
            ang_reg      <= est_arr_reg[ai_in];
            bias_old_reg <= bias_arr_reg[ai_in];
            p00_reg      <= p00_arr_reg[ai_in];
            p01_reg      <= p01_arr_reg[ai_in];
            p10_reg      <= p10_arr_reg[ai_in];
            p11_reg      <= p11_arr_reg[ai_in];
        end
        else if (step_done)
        begin
            case (op_reg)
                OP_ANG:
                begin
                    ang_reg <= ang_pred;
                    err_reg <= 33'(accel_reg) - 33'(ang_pred);
                end
                OP_P00:
                    p00_reg <= sat48(64'(p00_reg) + res_w);
                OP_P11DT:
                begin
                    p01_reg <= sat48(64'(p01_reg) - res_w);
                    p10_reg <= sat48(64'(p10_reg) - res_w);
                end
                OP_P11Q:
                begin
                    p11_reg <= sat48(64'(p11_reg) + res_w);
                    t0_reg  <= p00_reg;
                    t1_reg  <= p01_reg;
                end
                OP_K0:
                    k0_reg <= sat48(res_w);
                OP_K1:
                    k1_reg <= sat48(res_w);
                OP_U00:
                    p00_reg <= sat48(64'(p00_reg) - res_w);
                OP_U01:
                    p01_reg <= sat48(64'(p01_reg) - res_w);
                OP_U10:
                    p10_reg <= sat48(64'(p10_reg) - res_w);
                OP_U11:
                    p11_reg <= sat48(64'(p11_reg) - res_w);
                OP_CA:
                    ang_reg <= ang_pred;
                OP_CB:
                    rate_out_reg <= sat32(64'(gyro_reg) - 64'(bias_new));
                default:
                    ang_reg <= ang_reg;
            endcase
        end
    end

    assign m_tdata = {rate_out_reg, ang_reg};
    assign m_tuser = axis_reg;

    kabf_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_res),
        .done   (mul_done)
    );

    kabf_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (e_w),
        .result (div_res),
        .done   (div_done)
    );

endmodule

`default_nettype wire

>>> rtl/core/kabf_mul.sv
// kabf_mul: shared signed multiplier, 64x16 partial product per cycle, rounded shift and clamp.
// Depends on kabf_pkg.
`default_nettype none

module kabf_mul
    import kabf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mul_ctl_t           ctl,
    input  wire logic signed [63:0] a,
    input  wire logic signed [63:0] b,
    output logic signed [63:0]      result,
    output logic                    done
);

    logic [63:0]  ua_reg;
    logic [63:0]  ub_reg;
    logic         neg_reg;
    logic         sh40_reg;
    logic [127:0] acc_reg;
    logic [1:0]   cnt_reg;
    logic         busy_reg;
    logic         fin_reg;
    logic         done_reg;
    logic signed [63:0] res_reg;

    logic [79:0]  pp;
    logic [128:0] rnd;
    logic [128:0] shifted;
    logic [63:0]  mag;

    assign pp = ua_reg * ub_reg[63:48];

    always_comb
    begin
        rnd     = {1'b0, acc_reg} + (sh40_reg ? (129'd1 << 39) : (129'd1 << 27));
        shifted = sh40_reg ? (rnd >> 40) : (rnd >> 28);
        if ((|shifted[128:64]) || (shifted[63:0] > CLAMP_LIM))
            mag = CLAMP_LIM;
        else
            mag = shifted[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            ua_reg   <= magn(a);
            ub_reg   <= magn(b);
            neg_reg  <= a[63] ^ b[63];
            sh40_reg <= ctl.sh40;
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[111:0], 16'b0} + {48'b0, pp};
            ub_reg  <= {ub_reg[47:0], 16'b0};
        end
        else if (fin_reg)
        begin
            res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> rtl/core/kabf_div.sv
// kabf_div: radix-2 restoring divider, round(num * 2^40 / den) half away from zero, clamped.
// Depends on kabf_pkg.
`default_nettype none

module kabf_div
    import kabf_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [63:0] num,
    input  wire logic signed [63:0] den,
    output logic signed [63:0]      result,
    output logic                    done
);

    localparam int DIV_STEPS = 104;

    logic [103:0] dvd_reg;
    logic [63:0]  ud_reg;
    logic [64:0]  r_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic         neg_reg;
    logic [6:0]   cnt_reg;
    logic         busy_reg;
    logic         fin_reg;
    logic         done_reg;
    logic signed [63:0] res_reg;

    logic [64:0] r2;
    logic        ge;
    logic        rnd;
    logic [64:0] qr;
    logic [63:0] mag;

    always_comb
    begin
        r2  = {r_reg[63:0], dvd_reg[103]};
        ge  = r2 >= {1'b0, ud_reg};
        rnd = r_reg[63:0] >= (ud_reg - r_reg[63:0]);
        qr  = {1'b0, q_reg} + {64'b0, rnd};
        if (ovf_reg || (qr > {1'b0, CLAMP_LIM}))
            mag = CLAMP_LIM;
        else
            mag = qr[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= {magn(num), 40'b0};
            ud_reg  <= magn(den);
            neg_reg <= num[63] ^ den[63];
            r_reg   <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (q_reg > CLAMP_LIM)
                ovf_reg <= 1'b1;
            dvd_reg <= {dvd_reg[102:0], 1'b0};
            r_reg   <= ge ? (r2 - {1'b0, ud_reg}) : r2;
            q_reg   <= {q_reg[62:0], ge};
        end
        else if (fin_reg)
        begin
            res_reg <= neg_reg ? -$signed(mag) : $signed(mag);
        end
    end

    assign result = res_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

>>> test/testbench.sv
// testbench: self-checking test of angle_bias_kalman_filter_top over the stream and APB ports.
// Depends on kabf_pkg and the filter RTL. A built-in predictor computes each expected item.
`timescale 1ns / 1ps

module testbench;
    import kabf_pkg::*;

    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  N_AX = 2;
    localparam longint LIM62 = 64'sh4000000000000000;

    typedef struct {
        logic        axis;
        logic [31:0] angle;
        logic [31:0] rate;
    } filt_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    angle_bias_kalman_filter_top u_top (.*);

    always #5 clk = ~clk;

    // filter model state
    logic [31:0] dt_reg, qa_reg, qb_reg, r_reg;
    longint est_angle [N_AX];
    longint est_bias  [N_AX];
    longint cov00 [N_AX];
    longint cov01 [N_AX];
    longint cov10 [N_AX];
    longint cov11 [N_AX];

    filt_out_t pending_out[$];
    int  errors = 0;
    int  cycles = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  hold_cycles = 0;

    function automatic longint sat_to(input longint v, input int bits);
        longint hi, lo;
        hi = (64'sd1 <<< (bits - 1)) - 1;
        lo = -(64'sd1 <<< (bits - 1));
        return v > hi ? hi : (v < lo ? lo : v);
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int sh);
        logic [127:0] p;
        logic [63:0]  ua, ub;
        logic         neg;
        ua = a < 0 ? 64'(-a) : 64'(a);
        ub = b < 0 ? 64'(-b) : 64'(b);
        neg = (a < 0) != (b < 0);
        p = {64'b0, ua} * {64'b0, ub};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        if (p > 128'(LIM62))
            p = 128'(LIM62);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic longint div_round(input longint num, input longint den);
        logic [127:0] n, d, q, r;
        logic         neg;
        n = {64'b0, (num < 0 ? 64'(-num) : 64'(num))} << 40;
        d = {64'b0, (den < 0 ? 64'(-den) : 64'(den))};
        neg = (num < 0) != (den < 0);
        q = n / d;
        r = n % d;
        if (2 * r >= d)
            q = q + 1;
        if (q > 128'(LIM62))
            q = 128'(LIM62);
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic filt_out_t predict_filter(input logic ax, input logic [31:0] acc_u,
                                                 input logic [31:0] gyr_u);
        filt_out_t o;
        int     a;
        longint acc, gyr, dt, qa, qb, rr;
        longint p00, p01, p10, p11, n00, n01, n10, n11;
        longint ang, err, e, k0, k1, t0, t1, bias;
        a = int'(ax) % N_AX;
        acc = longint'(signed'(acc_u));
        gyr = longint'(signed'(gyr_u));
        dt = longint'(dt_reg);
        qa = longint'(qa_reg) <<< 12;
        qb = longint'(qb_reg) <<< 12;
        rr = longint'(r_reg) <<< 12;
        p00 = cov00[a]; p01 = cov01[a]; p10 = cov10[a]; p11 = cov11[a];
        k0 = 0;
        k1 = 0;
        ang = sat_to(est_angle[a] + mul_round(gyr - est_bias[a], dt, 28), 32);
        n00 = sat_to(p00 + mul_round(qa - p01 - p10, dt, 28), 48);
        n01 = sat_to(p01 - mul_round(p11, dt, 28), 48);
        n10 = sat_to(p10 - mul_round(p11, dt, 28), 48);
        n11 = sat_to(p11 + mul_round(qb, dt, 28), 48);
        p00 = n00; p01 = n01; p10 = n10; p11 = n11;
        err = acc - ang;
        e = rr + p00;
        if (e != 0)
        begin
            k0 = sat_to(div_round(p00, e), 48);
            k1 = sat_to(div_round(p10, e), 48);
        end
        t0 = p00;
        t1 = p01;
        p00 = sat_to(p00 - mul_round(k0, t0, 40), 48);
        p01 = sat_to(p01 - mul_round(k0, t1, 40), 48);
        p10 = sat_to(p10 - mul_round(k1, t0, 40), 48);
        p11 = sat_to(p11 - mul_round(k1, t1, 40), 48);
        ang = sat_to(ang + mul_round(k0, err, 40), 32);
        bias = sat_to(est_bias[a] + mul_round(k1, err, 40), 32);
        est_angle[a] = ang;
        est_bias[a] = bias;
        cov00[a] = p00; cov01[a] = p01; cov10[a] = p10; cov11[a] = p11;
        o.axis = ax;
        o.angle = ang[31:0];
        o.rate = 32'(sat_to(gyr - bias, 32));
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("ERROR at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        errors++;
    endtask

    // one item into s_
    task automatic send_item(input logic ax, input logic [31:0] acc, input logic [31:0] gyr);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6)) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser <= ax;
        s_tdata <= {gyr, acc};
        do @(posedge clk); while (!s_tready);
        pending_out.push_back(predict_filter(ax, acc, gyr));
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_STEP_TIME:     dt_reg = val;
            REG_ANGLE_NOISE:   qa_reg = val;
            REG_BIAS_NOISE:    qb_reg = val;
            REG_MEASURE_NOISE: r_reg = val;
        endcase
    endtask

    task automatic write_all(input logic [31:0] dt, input logic [31:0] qa,
                             input logic [31:0] qb, input logic [31:0] r);
        write_reg(REG_STEP_TIME, dt);
        write_reg(REG_ANGLE_NOISE, qa);
        write_reg(REG_BIAS_NOISE, qb);
        write_reg(REG_MEASURE_NOISE, r);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($urandom_range(0, 32'h00B40000)) - 32'h005A0000;
            2: return $urandom_range(1) ? 32'h7FFFFFFF - $urandom_range(3)
                                        : 32'h80000000 + $urandom_range(3);
            default: return 32'($urandom_range(0, 32'h00140000)) - 32'h000A0000;
        endcase
    endfunction

    // directed corners with reset defaults
    task automatic test_directed();
        send_item(1'b0, 32'h0, 32'h0);
        send_item(1'b1, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_item(1'b0, 32'h80000000, 32'h80000000);
        send_item(1'b1, 32'h80000000, 32'h7FFFFFFF);
        send_item(1'b0, 32'h7FFFFFFF, 32'h80000000);
        send_item(1'b0, 32'h001E0000, 32'hFFF60000);
        send_item(1'b1, 32'hFFFFFFFF, 32'h00000001);
        send_item(1'b1, 32'h00010000, 32'hFFFFFFFF);
        wait_drained();
    endtask

    // register extremes, including the smallest nonzero measurement noise
    task automatic test_config_extremes();
        write_all(32'hFFFFFFFF, 32'h0, 32'h0, 32'h1);
        repeat (6) send_item($urandom_range(1), rand_angle(), rand_angle());
        wait_drained();
        write_all(32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        repeat (6) send_item($urandom_range(1), rand_angle(), rand_angle());
        wait_drained();
        write_all(32'h10000000, 32'h0, 32'hFFFFFFFF, 32'h1);
        repeat (5) send_item($urandom_range(1), rand_angle(), rand_angle());
        wait_drained();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        if ($urandom_range(2) == 0)
            write_all($urandom, $urandom, $urandom, $urandom_range(32'hFFFFFFFF, 1));
        else
            write_all($urandom_range(32'h01000000), $urandom_range(32'h00100000),
                      $urandom_range(32'h00100000), $urandom_range(32'h20000000, 1));
        repeat (n) send_item($urandom_range(1), rand_angle(), rand_angle());
        wait_drained();
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 3000;
        repeat (12) send_item($urandom_range(1), rand_angle(), rand_angle());
        wait_drained();
    endtask

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        filt_out_t w;
        if (m_tvalid && m_tready)
        begin
            if (pending_out.size() == 0)
                report_mismatch("unexpected item", m_tdata[31:0], 32'h0);
            else
            begin
                w = pending_out.pop_front();
                if (m_tuser[0] !== w.axis)
                    report_mismatch("axis_out", {31'b0, m_tuser[0]}, {31'b0, w.axis});
                if (m_tdata[31:0] !== w.angle)
                    report_mismatch("filtered_angle", m_tdata[31:0], w.angle);
                if (m_tdata[63:32] !== w.rate)
                    report_mismatch("corrected_rate", m_tdata[63:32], w.rate);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        dt_reg = STEP_TIME_RST;
        qa_reg = ANGLE_NOISE_RST;
        qb_reg = BIAS_NOISE_RST;
        r_reg = MEASURE_NOISE_RST;
        for (int k = 0; k < N_AX; k++)
        begin
            est_angle[k] = 0;
            est_bias[k] = 0;
            cov00[k] = longint'(COV_ONE);
            cov01[k] = 0;
            cov10[k] = 0;
            cov11[k] = longint'(COV_ONE);
        end
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_config_extremes();
        test_random_phase(0, 0, 270);
        test_random_phase(59, 0, 270);
        test_random_phase(0, 59, 270);
        test_random_phase(14, 14, 270);
        test_backpressure();
        repeat (400) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
